@@ hdl/sorted_min_priority_queue_macros.svh @@
// Assertion macros for the sorted min-priority queue.
// Each macro checks on the rising edge of i_clk and is quiet while i_rst_n is low.
// SMPQ_ASSERT_SAME: the consequent holds in the same cycle as the antecedent.
// SMPQ_ASSERT_NEXT: the consequent holds in the cycle after the antecedent.
`ifndef SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH

`define SMPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("smpq check failed");

`define SMPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("smpq check failed");

`endif

@@ hdl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the sorted min-priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smpq_pkg;

    // Number of slots in the queue
    localparam int CAPACITY = 16;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int CNT_W    = 5;

    typedef logic [OCC_W-1:0] t_occ;
    typedef logic [CNT_W-1:0] t_cnt;

    // Request modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic signed [31:0] removed_priority;
        logic               is_empty;
        t_cnt               entry_count;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

@@ hdl/smpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer: capture a request, run one update of the slot array, then
// present the response for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output logic               o_valid,
    output smpq_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // A new request may enter while the previous response is on the ports
    assign busy    = (r_state == S_EXEC);
    assign o_valid = (r_state == S_DONE);
    assign accept  = start && !busy;

    assign o_cmd.capture = accept;
    assign o_cmd.execute = (r_state == S_EXEC);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/smpq_dp.sv @@
// ----------------------------------------------------------------------------
// smpq_dp
// Slot array kept sorted by priority. Every slot compares its priority with
// the request in parallel and decides locally to hold, take the new entry,
// or take a neighbor's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smpq_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smpq_pkg::t_dp_cmd  i_cmd,
    input  smpq_pkg::t_req     i_req,
    output smpq_pkg::t_rsp     o_rsp
);

    smpq_pkg::t_req     r_req;
    smpq_pkg::t_rsp     r_rsp;
    smpq_pkg::t_rsp     n_rsp;
    smpq_pkg::t_occ     r_occ;
    smpq_pkg::t_occ     n_occ;

    logic signed [31:0] r_val [smpq_pkg::CAPACITY];
    logic signed [31:0] r_pri [smpq_pkg::CAPACITY];
    logic signed [31:0] n_val [smpq_pkg::CAPACITY];
    logic signed [31:0] n_pri [smpq_pkg::CAPACITY];

    logic               ahead [smpq_pkg::CAPACITY];
    logic               is_ins;
    logic               is_rem;
    logic               full;
    logic               empty;
    logic               do_ins;
    logic               do_rem;
    logic               head_lt;

    assign is_ins = (r_req.mode == smpq_pkg::MODE_INSERT);
    assign is_rem = (r_req.mode == smpq_pkg::MODE_REMOVE);
    assign full   = (r_occ == smpq_pkg::t_occ'(smpq_pkg::CAPACITY));
    assign empty  = (r_occ == '0);
    assign do_ins = is_ins && !full;
    assign do_rem = is_rem && !empty;

    // A new entry goes past the head only if the head is strictly smaller
    assign head_lt = !empty && (r_pri[0] < r_req.item_priority);

    // Mark the slots that stay in front of the new entry
    always_comb begin
        ahead[0] = head_lt;
        for (int i = 1; i < smpq_pkg::CAPACITY; i++) begin
            ahead[i] = head_lt && (smpq_pkg::t_occ'(i) < r_occ)
                       && (r_pri[i] <= r_req.item_priority);
        end
    end

    // Next slot contents
    always_comb begin
        for (int i = 0; i < smpq_pkg::CAPACITY; i++) begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
        end
        if (do_ins) begin
            if (!ahead[0]) begin
                n_val[0] = r_req.item_value;
                n_pri[0] = r_req.item_priority;
            end
            for (int i = 1; i < smpq_pkg::CAPACITY; i++) begin
                if (!ahead[i]) begin
                    if (ahead[i-1]) begin
                        n_val[i] = r_req.item_value;
                        n_pri[i] = r_req.item_priority;
                    end else begin
                        n_val[i] = r_val[i-1];
                        n_pri[i] = r_pri[i-1];
                    end
                end
            end
        end else if (do_rem) begin
            for (int i = 0; i < smpq_pkg::CAPACITY - 1; i++) begin
                n_val[i] = r_val[i+1];
                n_pri[i] = r_pri[i+1];
            end
        end
    end

    // Next occupancy and response
    always_comb begin
        n_occ = r_occ;
        if (do_ins) begin
            n_occ = r_occ + smpq_pkg::t_occ'(1);
        end else if (do_rem) begin
            n_occ = r_occ - smpq_pkg::t_occ'(1);
        end

        n_rsp.status           = smpq_pkg::ST_DONE;
        n_rsp.removed_value    = '0;
        n_rsp.removed_priority = '0;
        if (is_ins && full) begin
            n_rsp.status = smpq_pkg::ST_FULL;
        end else if (is_rem && empty) begin
            n_rsp.status = smpq_pkg::ST_EMPTY;
        end else if (do_rem) begin
            n_rsp.removed_value    = r_val[0];
            n_rsp.removed_priority = r_pri[0];
        end
        n_rsp.is_empty    = (n_occ == '0);
        n_rsp.entry_count = smpq_pkg::t_cnt'(n_occ);
    end

    // Hold the request for the update cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    // Update slots and response
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            for (int i = 0; i < smpq_pkg::CAPACITY; i++) begin
                r_val[i] <= n_val[i];
                r_pri[i] <= n_pri[i];
            end
            r_rsp <= n_rsp;
        end
    end

    // Occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.execute) begin
            r_occ <= n_occ;
        end
    end

    assign o_rsp = r_rsp;

endmodule

@@ hdl/sorted_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// A taken start loads the capture register; the slot array and response
// register update, then o_valid strobes; a new request may be taken in the
// cycle its predecessor's response is shown. The pace is set by the capture
// register and the single compare-and-shift update of the slot array.
// Reset clears the controller and occupancy; slot contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_min_priority_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  smpq_pkg::t_req  i_req,
    output logic            o_valid,
    output smpq_pkg::t_rsp  o_rsp
);

    smpq_pkg::t_dp_cmd cmd;

    // Sequencer
    smpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Slot array and response register
    smpq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

@@ hdl/smpq_checker.sv @@
// ----------------------------------------------------------------------------
// smpq_assert
// Port-level checks of request sequencing and response consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_min_priority_queue_macros.svh"

module smpq_assert (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            o_valid,
    input  smpq_pkg::t_rsp  o_rsp
);

    logic show_full;
    logic show_empty;
    logic pop_zero;

    // Decode the strobed status
    assign show_full  = o_valid && (o_rsp.status == smpq_pkg::ST_FULL);
    assign show_empty = o_valid && (o_rsp.status == smpq_pkg::ST_EMPTY);
    assign pop_zero   = (o_rsp.removed_value == '0) && (o_rsp.removed_priority == '0);

    // A taken request makes the block busy in the next cycle
    `SMPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // Every update cycle ends in a response
    `SMPQ_ASSERT_NEXT(a_busy_resp, busy, o_valid && !busy)
    // Dropped inserts only happen on a non-empty queue
    `SMPQ_ASSERT_SAME(a_full_nonempty, show_full, !o_rsp.is_empty)
    // An empty remove pops nothing
    `SMPQ_ASSERT_SAME(a_empty_zero, show_empty, o_rsp.is_empty && pop_zero)

endmodule

bind sorted_min_priority_queue smpq_assert u_smpq_assert (.*);

@@ bench/smpq_checker.sv @@
// ----------------------------------------------------------------------------
// smpq_checker
// Watches the request and response channels of the sorted min-priority
// queue. It keeps its own copy of the slot array, works out the response of
// every transferred request, and compares each strobed response with the
// oldest one waiting. It reports the failure count and the number of
// responses still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smpq_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  smpq_pkg::t_req  i_req,
    input  logic            i_valid,
    input  smpq_pkg::t_rsp  i_rsp,
    output int              o_fail_count,
    output int              o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Shadow of the queue contents, head at slot 0
    logic signed [31:0] slot_val [smpq_pkg::CAPACITY];
    logic signed [31:0] slot_pri [smpq_pkg::CAPACITY];
    smpq_pkg::t_occ     slot_count;

    smpq_pkg::t_rsp owed_rsp_q [$];
    int             fail_total;

    // Apply one request to the shadow queue and return its response
    function automatic smpq_pkg::t_rsp serve_request(smpq_pkg::t_req req);
        smpq_pkg::t_rsp     rsp;
        logic signed [31:0] new_pri;
        int                 pos;
        int                 idx;
        rsp     = '0;
        new_pri = req.item_priority;
        pos     = 0;
        case (req.mode)
            smpq_pkg::MODE_INSERT: begin
                if (slot_count >= smpq_pkg::CAPACITY) begin
                    rsp.status = smpq_pkg::ST_FULL;
                end else begin
                    // Equal to the head goes in front; otherwise behind all equals
                    if (slot_count != 0 && !(new_pri <= slot_pri[0])) begin
                        pos = 1;
                        while (pos < int'(slot_count) && slot_pri[pos] <= new_pri)
                            pos++;
                    end
                    for (idx = int'(slot_count); idx > pos; idx--) begin
                        slot_val[idx] = slot_val[idx-1];
                        slot_pri[idx] = slot_pri[idx-1];
                    end
                    slot_val[pos] = req.item_value;
                    slot_pri[pos] = new_pri;
                    slot_count    = slot_count + 1'b1;
                    rsp.status    = smpq_pkg::ST_DONE;
                end
            end
            smpq_pkg::MODE_REMOVE: begin
                if (slot_count == 0) begin
                    rsp.status = smpq_pkg::ST_EMPTY;
                end else begin
                    rsp.removed_value    = slot_val[0];
                    rsp.removed_priority = slot_pri[0];
                    for (idx = 1; idx < int'(slot_count); idx++) begin
                        slot_val[idx-1] = slot_val[idx];
                        slot_pri[idx-1] = slot_pri[idx];
                    end
                    slot_count = slot_count - 1'b1;
                    rsp.status = smpq_pkg::ST_DONE;
                end
            end
            default: begin
                // Query and the spare mode change nothing
                rsp.status = smpq_pkg::ST_DONE;
            end
        endcase
        rsp.is_empty    = (slot_count == 0);
        rsp.entry_count = smpq_pkg::t_cnt'(slot_count);
        return rsp;
    endfunction

    // Compare strobed responses first, then record the new transfer
    always @(posedge i_clk) begin
        smpq_pkg::t_rsp want;
        if (!i_rst_n) begin
            slot_count = '0;
            owed_rsp_q.delete();
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                if (owed_rsp_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: unexpected st=%0d val=%0d pri=%0d emp=%0d cnt=%0d",
                                 $realtime, i_rsp.status, i_rsp.removed_value,
                                 i_rsp.removed_priority, i_rsp.is_empty, i_rsp.entry_count);
                end else begin
                    want = owed_rsp_q.pop_front();
                    if (i_rsp.status !== want.status
                            || i_rsp.removed_value !== want.removed_value
                            || i_rsp.removed_priority !== want.removed_priority
                            || i_rsp.is_empty !== want.is_empty
                            || i_rsp.entry_count !== want.entry_count) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: exp st=%0d val=%0d pri=%0d emp=%0d cnt=%0d",
                                     $realtime, want.status, want.removed_value,
                                     want.removed_priority, want.is_empty, want.entry_count);
                            $display("%0t: got st=%0d val=%0d pri=%0d emp=%0d cnt=%0d",
                                     $realtime, i_rsp.status, i_rsp.removed_value,
                                     i_rsp.removed_priority, i_rsp.is_empty, i_rsp.entry_count);
                        end
                    end
                end
            end
            if (i_start && !i_busy)
                owed_rsp_q.push_back(serve_request(i_req));
            o_pending <= owed_rsp_q.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the sorted min-priority queue with a directed run through empty,
// full, equal-priority and extreme-priority cases, then with random requests
// in phases of differing sender idling, and gives the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         ITEMS       = 800;
    localparam int         BLOCK_ITEMS = 40;
    localparam int         STALL_LIMIT = 1000;
    localparam int         END_CYCLES  = 6;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    logic           busy;
    smpq_pkg::t_req req_d   = '0;
    logic           o_valid;
    smpq_pkg::t_rsp o_rsp;

    int fail_count;
    int owed_count;
    int quiet_cycles = 0;

    sorted_min_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req_d),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    smpq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req_d),
        .i_valid      (o_valid),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (owed_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL sorted_min_priority_queue");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request, hold it until transferred, then maybe idle
    task automatic send_req(input logic [1:0] mode, input logic [31:0] val,
                            input logic [31:0] pri, input int idle_pct);
        smpq_pkg::t_req req;
        req.mode          = mode;
        req.item_value    = val;
        req.item_priority = pri;
        start <= 1'b1;
        req_d <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Hold off until every owed response has arrived
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (owed_count != 0);
    endtask

    initial begin
        int          phase_idle [3];
        int          phase;
        int          n;
        int          insert_pct;
        int          pick;
        logic [1:0]  mode;
        logic [31:0] pri;

        phase_idle[0] = 0;
        phase_idle[1] = 52;
        phase_idle[2] = 9;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: query, remove, spare mode
        send_req(smpq_pkg::MODE_QUERY, 32'h1234_5678, 32'h8765_4321, 0);
        send_req(smpq_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_req(MODE_SPARE, 32'h0, 32'h0, 0);

        // Equal to head goes first, extremes of priority and value
        send_req(smpq_pkg::MODE_INSERT, 32'h0000_0011, 32'd5, 0);
        send_req(smpq_pkg::MODE_INSERT, 32'h0000_0022, 32'd5, 0);
        send_req(smpq_pkg::MODE_INSERT, 32'h0000_0033, 32'h7FFF_FFFF, 0);
        send_req(smpq_pkg::MODE_INSERT, 32'h0000_0044, 32'h8000_0000, 0);
        send_req(smpq_pkg::MODE_INSERT, 32'h0000_0055, 32'd5, 0);
        send_req(smpq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_req(smpq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_req(smpq_pkg::MODE_INSERT, 32'h8000_0000, 32'h0, 0);

        // Fill to capacity with repeated priorities
        for (n = 0; n < 8; n++)
            send_req(smpq_pkg::MODE_INSERT, 32'hA000_0000 + n, n % 3, 0);

        // Full: dropped insert, then query and a few pops
        send_req(smpq_pkg::MODE_INSERT, 32'hDEAD_BEEF, 32'h8000_0000, 0);
        send_req(smpq_pkg::MODE_QUERY, 32'h0, 32'h0, 0);
        for (n = 0; n < 3; n++)
            send_req(smpq_pkg::MODE_REMOVE, 32'h0, 32'h0, 0);

        // Random phases; insert share changes per block to swing full and empty
        for (phase = 0; phase < 3; phase++) begin
            drain();
            insert_pct = 50;
            for (n = 0; n < ITEMS / 3; n++) begin
                if (n % BLOCK_ITEMS == 0) begin
                    case ($urandom_range(0, 2))
                        0: insert_pct = 72;
                        1: insert_pct = 25;
                        default: insert_pct = 48;
                    endcase
                end
                pick = $urandom_range(0, 99);
                if (pick < insert_pct)
                    mode = smpq_pkg::MODE_INSERT;
                else if (pick < 96)
                    mode = smpq_pkg::MODE_REMOVE;
                else if (pick < 98)
                    mode = smpq_pkg::MODE_QUERY;
                else
                    mode = MODE_SPARE;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: pri = $urandom_range(0, 15) - 8;
                    5, 6, 7:       pri = $urandom;
                    8:             pri = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default:       pri = $urandom_range(0, 1);
                endcase
                send_req(mode, $urandom, pri, phase_idle[phase]);
            end
        end

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sorted_min_priority_queue");
        end else begin
            $display("FAIL sorted_min_priority_queue");
        end
        $finish;
    end

endmodule
